### rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// UV sphere package
// Shared types, register indexes and fixed-point helpers for the sphere mesh
// generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [REG_IDX_W-1:0] REG_RADIUS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SECTORS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STACKS  = 2'd2;

  localparam logic [15:0] RADIUS_RESET  = 16'd256;
  localparam logic [8:0]  SECTORS_RESET = 9'd36;
  localparam logic [8:0]  STACKS_RESET  = 9'd18;

  localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
  localparam logic [31:0] Q30_ONE      = 32'h4000_0000;
  localparam logic [63:0] Q30_HALF     = 64'h2000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam int          HORNER_STEPS = 6;

  typedef struct packed {
    logic signed [31:0] sinv;
    logic signed [31:0] cosv;
    logic [16:0]        tex;
  } tbl_entry_t;

  function automatic logic [7:0] horner_div(input logic [2:0] k);
    logic [7:0] d;
    case (k)
      3'd0: d = 8'd156;
      3'd1: d = 8'd110;
      3'd2: d = 8'd72;
      3'd3: d = 8'd42;
      3'd4: d = 8'd20;
      3'd5: d = 8'd6;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  // Reciprocals floor(2^32 / d) of the series divisors.
  function automatic logic [31:0] horner_recip(input logic [2:0] k);
    logic [31:0] m;
    case (k)
      3'd0: m = 32'd27531841;
      3'd1: m = 32'd39045157;
      3'd2: m = 32'd59652323;
      3'd3: m = 32'd102261126;
      3'd4: m = 32'd214748364;
      3'd5: m = 32'd715827882;
      default: m = 32'd715827882;
    endcase
    return m;
  endfunction

  // Shift right with rounding half away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

### rtl/uv_sphere_triangle_generator.sv
// ----------------------------------------------------------------------------
// UV sphere triangle generator
// The first vertex of an accepted cell passes through the job queue, the table
// read and the back-end pipeline, then one vertex per cycle follows: six vertices
// per cell, three on the top and bottom rows, and none for a cell out of range.
// After reset and after each count write the trig tables are rebuilt, one entry
// at a time over (stacks + sectors + 2) entries, with busy high.
// Results cannot be stalled; every cell-to-vertex stage runs at one per cycle.
// ----------------------------------------------------------------------------
module uv_sphere_triangle_generator import uvs_pkg::*; #(
  parameter int MAX_SECTORS = 256,
  parameter int MAX_STACKS  = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [REG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  start,
  input  logic [7:0]            stack_row,
  input  logic [7:0]            sector_column,
  output logic                  busy,
  output logic                  vertex_valid,
  output logic signed [16:0]    pos_x,
  output logic signed [16:0]    pos_y,
  output logic signed [16:0]    pos_z,
  output logic signed [15:0]    norm_x,
  output logic signed [15:0]    norm_y,
  output logic signed [15:0]    norm_z,
  output logic [16:0]           tex_s,
  output logic [16:0]           tex_t,
  output logic                  last_vertex
);

  localparam int CCW = $clog2(MAX_SECTORS + 1);
  localparam int SCW = $clog2(MAX_STACKS + 1);
  localparam int CW  = (CCW > SCW) ? CCW : SCW;

  logic [15:0]    radius_q8_8;
  logic [8:0]     sector_count;
  logic [8:0]     stack_count;
  logic [CCW-1:0] nc;
  logic [SCW-1:0] ns;
  logic           restart;
  logic           fill_busy;
  logic           front_busy;
  logic           we_stack;
  logic           we_sector;
  logic [CW-1:0]  fill_waddr;
  tbl_entry_t     fill_wdata;
  logic           job_valid;
  logic [SCW-1:0] job_i;
  logic [CCW-1:0] job_j;
  logic           job_last;
  logic [SCW-1:0] stack_raddr;
  logic [CCW-1:0] sector_raddr;
  tbl_entry_t     stack_rdata;
  tbl_entry_t     sector_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_q8_8  <= RADIUS_RESET;
      sector_count <= SECTORS_RESET;
      stack_count  <= STACKS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_RADIUS:  radius_q8_8  <= cfg_wdata;
        REG_SECTORS: sector_count <= cfg_wdata[8:0];
        REG_STACKS:  stack_count  <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nc      = (32'(sector_count) > MAX_SECTORS) ? CCW'(MAX_SECTORS) : CCW'(sector_count);
    ns      = (32'(stack_count) > MAX_STACKS) ? SCW'(MAX_STACKS) : SCW'(stack_count);
    restart = cfg_wr_en && ((cfg_addr == REG_SECTORS) || (cfg_addr == REG_STACKS));
    busy    = fill_busy || front_busy;
  end

  uvs_fill #(.CW(CW)) u_fill (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .ns        (CW'(ns)),
    .nc        (CW'(nc)),
    .busy      (fill_busy),
    .we_stack  (we_stack),
    .we_sector (we_sector),
    .waddr     (fill_waddr),
    .wdata     (fill_wdata)
  );

  uvs_ram #(.WIDTH($bits(tbl_entry_t)), .DEPTH(MAX_STACKS + 1)) u_stack_ram (
    .clk   (clk),
    .we    (we_stack),
    .waddr (fill_waddr[SCW-1:0]),
    .wdata (fill_wdata),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  uvs_ram #(.WIDTH($bits(tbl_entry_t)), .DEPTH(MAX_SECTORS + 1)) u_sector_ram (
    .clk   (clk),
    .we    (we_sector),
    .waddr (fill_waddr[CCW-1:0]),
    .wdata (fill_wdata),
    .raddr (sector_raddr),
    .rdata (sector_rdata)
  );

  uvs_front #(.SAW(SCW), .CAW(CCW)) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start && !fill_busy),
    .stack_row     (stack_row),
    .sector_column (sector_column),
    .ns            (ns),
    .nc            (nc),
    .busy          (front_busy),
    .job_valid     (job_valid),
    .job_i         (job_i),
    .job_j         (job_j),
    .job_last      (job_last)
  );

  uvs_back #(.SAW(SCW), .CAW(CCW)) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job_i        (job_i),
    .job_j        (job_j),
    .job_last     (job_last),
    .radius       (radius_q8_8),
    .stack_raddr  (stack_raddr),
    .sector_raddr (sector_raddr),
    .stack_rdata  (stack_rdata),
    .sector_rdata (sector_rdata),
    .vertex_valid (vertex_valid),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .norm_x       (norm_x),
    .norm_y       (norm_y),
    .norm_z       (norm_z),
    .tex_s        (tex_s),
    .tex_t        (tex_t),
    .last_vertex  (last_vertex)
  );

endmodule

### rtl/uvs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module uvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/uvs_sin.sv
// ----------------------------------------------------------------------------
// Iterative sine unit
// Computes a Q1.30 sine of a 32-bit phase with one shared multiplier,
// stepping through the range reduction and the series evaluation.
// ----------------------------------------------------------------------------
module uvs_sin import uvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        phase,
  output logic               done,
  output logic signed [31:0] y
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_X    = 7'b0000010,
    S_X2   = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIX  = 7'b0100000,
    S_Y    = 7'b1000000
  } sin_state_t;

  sin_state_t  state;
  logic [1:0]  quad;
  logic [30:0] r;
  logic [30:0] x;
  logic [31:0] x2;
  logic [30:0] h;
  logic [31:0] v;
  logic [31:0] q0;
  logic [2:0]  k;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] rounded;
  logic [31:0] rem;
  logic [31:0] q;
  logic [31:0] yabs;

  always_comb begin
    case (state)
      S_X: begin
        mul_a = {1'b0, r};
        mul_b = HALF_PI_Q30;
      end
      S_X2: begin
        mul_a = {1'b0, x};
        mul_b = {1'b0, x};
      end
      S_MUL: begin
        mul_a = x2;
        mul_b = {1'b0, h};
      end
      S_DIV: begin
        mul_a = v;
        mul_b = horner_recip(k);
      end
      S_Y: begin
        mul_a = {1'b0, x};
        mul_b = {1'b0, h};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
    prod    = mul_a * mul_b;
    rounded = (prod + Q30_HALF) >> 30;
    rem     = v - 32'(q0 * horner_div(k));
    q       = (rem >= 32'(horner_div(k))) ? q0 + 32'd1 : q0;
    yabs    = (rounded > 64'(Q30_ONE)) ? Q30_ONE : rounded[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_Y);
      case (state)
        S_IDLE: begin
          if (start) begin
            quad  <= phase[31:30];
            r     <= phase[30] ? Q30_ONE[30:0] - {1'b0, phase[29:0]} : {1'b0, phase[29:0]};
            state <= S_X;
          end
        end
        S_X: begin
          x     <= rounded[30:0];
          state <= S_X2;
        end
        S_X2: begin
          x2    <= rounded[31:0];
          h     <= Q30_ONE[30:0];
          k     <= 3'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          v     <= prod[61:30];
          state <= S_DIV;
        end
        S_DIV: begin
          q0    <= prod[63:32];
          state <= S_FIX;
        end
        S_FIX: begin
          h <= 31'(Q30_ONE - q);
          k <= k + 3'd1;
          if (k == 3'(HORNER_STEPS - 1)) begin
            state <= S_Y;
          end else begin
            state <= S_MUL;
          end
        end
        S_Y: begin
          y     <= quad[1] ? -$signed(yabs) : $signed(yabs);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/uvs_fill.sv
// ----------------------------------------------------------------------------
// Table builder
// Fills the stack and sector tables with sine, cosine and texture values for
// every grid index, using exact incremental division and the sine unit.
// ----------------------------------------------------------------------------
module uvs_fill import uvs_pkg::*; #(
  parameter int CW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          restart,
  input  logic [CW-1:0] ns,
  input  logic [CW-1:0] nc,
  output logic          busy,
  output logic          we_stack,
  output logic          we_sector,
  output logic [CW-1:0] waddr,
  output tbl_entry_t    wdata
);

  typedef enum logic [7:0] {
    F_IDLE  = 8'b00000001,
    F_LOAD  = 8'b00000010,
    F_DIV   = 8'b00000100,
    F_SINA  = 8'b00001000,
    F_WAITA = 8'b00010000,
    F_SINB  = 8'b00100000,
    F_WAITB = 8'b01000000,
    F_WRITE = 8'b10000000
  } fill_state_t;

  fill_state_t        state;
  logic               tsel;
  logic               dsel;
  logic [CW-1:0]      n;
  logic [CW:0]        divisor;
  logic [32:0]        dvd;
  logic [CW:0]        rem_r;
  logic [32:0]        quo;
  logic [5:0]         bitcnt;
  logic [31:0]        pq;
  logic [CW-1:0]      pr;
  logic [16:0]        tq_step;
  logic [CW:0]        tr_step;
  logic [31:0]        ph;
  logic [CW-1:0]      phr;
  logic [16:0]        tq;
  logic [CW:0]        tr;
  logic [CW-1:0]      idx;
  logic signed [31:0] sa;
  logic signed [31:0] sb;
  logic [CW-1:0]      n_sel;
  logic [CW+1:0]      rr;
  logic               ge;
  logic [CW:0]        rnext;
  logic [CW:0]        psum;
  logic               pcarry;
  logic [CW+1:0]      tsum;
  logic               tcarry;
  logic               sin_start;
  logic [31:0]        sin_phase;
  logic               sin_done;
  logic signed [31:0] sin_y;

  uvs_sin u_sin (
    .clk   (clk),
    .rst   (rst),
    .start (sin_start),
    .phase (sin_phase),
    .done  (sin_done),
    .y     (sin_y)
  );

  always_comb begin
    n_sel     = tsel ? nc : ns;
    rr        = {rem_r, dvd[32]};
    ge        = (rr >= {1'b0, divisor});
    rnext     = ge ? (CW+1)'(rr - {1'b0, divisor}) : rr[CW:0];
    psum      = {1'b0, phr} + {1'b0, pr};
    pcarry    = (psum >= {1'b0, n});
    tsum      = {1'b0, tr} + {1'b0, tr_step};
    tcarry    = (tsum >= {1'b0, n, 1'b0});
    sin_start = (state == F_SINA) || (state == F_SINB);
    sin_phase = (state == F_SINB) ? ph + QUARTER_TURN : ph;
    busy      = (state != F_IDLE);
    we_stack  = (state == F_WRITE) && !tsel;
    we_sector = (state == F_WRITE) && tsel;
    waddr     = idx;
    wdata     = '{sinv: sa, cosv: sb, tex: tq};
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= F_LOAD;
      tsel  <= 1'b0;
    end else begin
      case (state)
        F_LOAD: begin
          if (n_sel == '0) begin
            if (tsel) begin
              state <= F_IDLE;
            end else begin
              tsel <= 1'b1;
            end
          end else begin
            n       <= n_sel;
            divisor <= {1'b0, n_sel};
            dvd     <= tsel ? 33'h1_0000_0000 : 33'h0_8000_0000;
            rem_r   <= '0;
            quo     <= '0;
            bitcnt  <= 6'd0;
            dsel    <= 1'b0;
            state   <= F_DIV;
          end
        end
        F_DIV: begin
          if ((bitcnt == 6'd32) && !dsel) begin
            pq      <= {quo[30:0], ge};
            pr      <= rnext[CW-1:0];
            dsel    <= 1'b1;
            divisor <= {n, 1'b0};
            dvd     <= 33'h0_0002_0000;
            rem_r   <= '0;
            quo     <= '0;
            bitcnt  <= 6'd0;
          end else begin
            dvd    <= {dvd[31:0], 1'b0};
            rem_r  <= rnext;
            quo    <= {quo[31:0], ge};
            bitcnt <= bitcnt + 6'd1;
            if (bitcnt == 6'd32) begin
              tq_step <= {quo[15:0], ge};
              tr_step <= rnext;
              ph      <= 32'd0;
              phr     <= '0;
              tq      <= 17'd0;
              tr      <= {1'b0, n};
              idx     <= '0;
              state   <= F_SINA;
            end
          end
        end
        F_SINA: state <= F_WAITA;
        F_WAITA: begin
          if (sin_done) begin
            sa    <= sin_y;
            state <= F_SINB;
          end
        end
        F_SINB: state <= F_WAITB;
        F_WAITB: begin
          if (sin_done) begin
            sb    <= sin_y;
            state <= F_WRITE;
          end
        end
        F_WRITE: begin
          phr <= pcarry ? CW'(psum - {1'b0, n}) : psum[CW-1:0];
          ph  <= ph + pq + 32'(pcarry);
          tr  <= tcarry ? (CW+1)'(tsum - {1'b0, n, 1'b0}) : tsum[CW:0];
          tq  <= tq + tq_step + 17'(tcarry);
          if (idx == n) begin
            if (tsel) begin
              state <= F_IDLE;
            end else begin
              tsel  <= 1'b1;
              state <= F_LOAD;
            end
          end else begin
            idx   <= idx + CW'(1);
            state <= F_SINA;
          end
        end
        F_IDLE: state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### rtl/uvs_front.sv
// ----------------------------------------------------------------------------
// Cell front end
// Accepts grid cells, checks them against the grid size, expands each into
// its vertex sequence and queues the vertex jobs for the back end.
// ----------------------------------------------------------------------------
module uvs_front import uvs_pkg::*; #(
  parameter int SAW = 9,
  parameter int CAW = 9
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [7:0]     stack_row,
  input  logic [7:0]     sector_column,
  input  logic [SAW-1:0] ns,
  input  logic [CAW-1:0] nc,
  output logic           busy,
  output logic           job_valid,
  output logic [SAW-1:0] job_i,
  output logic [CAW-1:0] job_j,
  output logic           job_last
);

  localparam int JW  = SAW + CAW + 1;
  localparam int QD  = 4;
  localparam int QAW = $clog2(QD);

  localparam logic [2:0] SLOT_UP_FIRST = 3'd0;
  localparam logic [2:0] SLOT_UP_LAST  = 3'd2;
  localparam logic [2:0] SLOT_LO_FIRST = 3'd3;
  localparam logic [2:0] SLOT_LO_LAST  = 3'd5;

  logic [JW-1:0]  queue [QD];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           active;
  logic [2:0]     k;
  logic [2:0]     kend;
  logic [SAW-1:0] base_i;
  logic [CAW-1:0] base_j;
  logic           full;
  logic           push;
  logic           pop;
  logic           is_last;
  logic           di;
  logic           dj;
  logic [JW-1:0]  push_job;
  logic           accept;
  logic           in_range;
  logic           upper;
  logic           lower;

  always_comb begin
    case (k)
      3'd0:    {di, dj} = 2'b10;
      3'd1:    {di, dj} = 2'b01;
      3'd2:    {di, dj} = 2'b00;
      3'd3:    {di, dj} = 2'b10;
      3'd4:    {di, dj} = 2'b11;
      3'd5:    {di, dj} = 2'b01;
      default: {di, dj} = 2'b00;
    endcase
    full     = (count == (QAW+1)'(QD));
    push     = active && !full;
    pop      = (count != '0);
    is_last  = (k == kend);
    push_job = {is_last, base_j + CAW'(dj), base_i + SAW'(di)};
    busy     = active && !(push && is_last);
    accept   = start && !busy;
    in_range = (nc != '0) && (ns != '0) && (32'(stack_row) < 32'(ns))
               && (32'(sector_column) < 32'(nc));
    upper    = (stack_row != 8'd0);
    lower    = (32'(stack_row) + 32'd1 != 32'(ns));
    job_valid = pop;
    {job_last, job_j, job_i} = queue[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        queue[wr_ptr] <= push_job;
        wr_ptr        <= wr_ptr + QAW'(1);
        if (!is_last) begin
          k <= k + 3'd1;
        end
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
      if (accept) begin
        active <= in_range && (upper || lower);
        k      <= upper ? SLOT_UP_FIRST : SLOT_LO_FIRST;
        kend   <= lower ? SLOT_LO_LAST : SLOT_UP_LAST;
        base_i <= SAW'(stack_row);
        base_j <= CAW'(sector_column);
      end else if (push && is_last) begin
        active <= 1'b0;
      end
    end
  end

endmodule

### rtl/uvs_back.sv
// ----------------------------------------------------------------------------
// Vertex back end
// Looks up the trig terms of one grid vertex per cycle and forms the scaled
// position, the normal and the texture coordinate in a short pipeline.
// ----------------------------------------------------------------------------
module uvs_back import uvs_pkg::*; #(
  parameter int SAW = 9,
  parameter int CAW = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  logic [SAW-1:0]     job_i,
  input  logic [CAW-1:0]     job_j,
  input  logic               job_last,
  input  logic [15:0]        radius,
  output logic [SAW-1:0]     stack_raddr,
  output logic [CAW-1:0]     sector_raddr,
  input  tbl_entry_t         stack_rdata,
  input  tbl_entry_t         sector_rdata,
  output logic               vertex_valid,
  output logic signed [16:0] pos_x,
  output logic signed [16:0] pos_y,
  output logic signed [16:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [16:0]        tex_s,
  output logic [16:0]        tex_t,
  output logic               last_vertex
);

  logic               v1, v2, v3, v4;
  logic               l1, l2, l3, l4;
  logic signed [63:0] prod_x2;
  logic signed [63:0] prod_z2;
  logic signed [31:0] py2;
  logic [16:0]        ts2, tt2;
  logic signed [31:0] px3, py3, pz3;
  logic [16:0]        ts3, tt3;
  logic signed [47:0] mx4, my4, mz4;
  logic signed [15:0] nx4, ny4, nz4;
  logic [16:0]        ts4, tt4;
  logic signed [63:0] rx, ry, rz;
  logic signed [63:0] qx, qy, qz;
  logic signed [63:0] gx, gy, gz;
  logic signed [16:0] rad;

  assign stack_raddr  = job_i;
  assign sector_raddr = job_j;

  always_comb begin
    rad = $signed({1'b0, radius});
    rx  = rnd_shift(prod_x2, 30);
    rz  = rnd_shift(prod_z2, 30);
    qx  = rnd_shift(64'(px3), 16);
    qy  = rnd_shift(64'(py3), 16);
    qz  = rnd_shift(64'(pz3), 16);
    gx  = rnd_shift(64'(mx4), 30);
    gy  = rnd_shift(64'(my4), 30);
    gz  = rnd_shift(64'(mz4), 30);
    ry  = 64'(py2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      vertex_valid <= 1'b0;
    end else begin
      v1           <= job_valid;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      vertex_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    l1 <= job_last;

    prod_x2 <= stack_rdata.sinv * sector_rdata.sinv;
    prod_z2 <= stack_rdata.sinv * sector_rdata.cosv;
    py2     <= stack_rdata.cosv;
    ts2     <= sector_rdata.tex;
    tt2     <= stack_rdata.tex;
    l2      <= l1;

    px3 <= rx[31:0];
    pz3 <= rz[31:0];
    py3 <= ry[31:0];
    ts3 <= ts2;
    tt3 <= tt2;
    l3  <= l2;

    mx4 <= rad * px3;
    my4 <= rad * py3;
    mz4 <= rad * pz3;
    nx4 <= qx[15:0];
    ny4 <= qy[15:0];
    nz4 <= qz[15:0];
    ts4 <= ts3;
    tt4 <= tt3;
    l4  <= l3;

    pos_x       <= gx[16:0];
    pos_y       <= gy[16:0];
    pos_z       <= gz[16:0];
    norm_x      <= nx4;
    norm_y      <= ny4;
    norm_z      <= nz4;
    tex_s       <= ts4;
    tex_t       <= tt4;
    last_vertex <= l4;
  end

endmodule
